// File: rtl/assert_macros.svh
// Assertion macros for the RTL files that carry checks.
// Each expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication with a fixed delay in cycles, disabled while in reset.
`define ASSERT_DELAY(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ## dly (cons)) \
        else $error(msg);

`endif

// File: rtl/rtli_pkg.sv
// Shared types, rate/temperature tables and width helpers for the rate table interpolator.
// No dependencies; every RTL module imports this package.
package rtli_pkg;

    localparam int KIND_W             = 2;
    localparam int TEMP_W             = 24;
    localparam int RATE_W             = 28;
    localparam int TPOINT_W           = 15;
    localparam int HH_POINTS          = 19;
    localparam int EH_PH_POINTS       = 17;
    localparam int MAX_POINTS         = (HH_POINTS > EH_PH_POINTS) ? HH_POINTS : EH_PH_POINTS;
    localparam int IDX_W              = $clog2(MAX_POINTS);
    localparam int DEF_TEMP_FRAC_BITS = 8;
    localparam int DIV_STEP           = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_HH = 2'd0,
        KIND_EH = 2'd1,
        KIND_PH = 2'd2
    } t_kind;

    typedef logic [TPOINT_W-1:0] t_tpoint;
    typedef logic [RATE_W-1:0]   t_rate;
    typedef logic [IDX_W-1:0]    t_idx;

    localparam t_rate RATE_MAX = '1;

    // Side information that rides along with each transaction.
    typedef struct packed {
        logic  none;
        logic  ext;
        t_rate k_lo;
    } t_tag;

    localparam t_tpoint HH_TEMP [HH_POINTS] = '{
        1, 2, 4, 6, 8, 10, 15, 20, 25, 30, 40, 50, 60, 70, 80, 90, 100, 200, 300
    };
    localparam t_rate HH_RATE [HH_POINTS] = '{
        1380, 1430, 2710, 6600, 14700, 28800, 91000, 178000, 273000, 367000,
        538000, 686000, 814000, 925000, 1020000, 1110000, 1190000, 1750000,
        2090000
    };
    localparam t_tpoint XH_TEMP [EH_PH_POINTS] = '{
        1, 2, 5, 10, 20, 50, 100, 200, 500, 1000, 2000, 3000, 5000, 7000,
        10000, 15000, 20000
    };
    localparam t_rate EH_RATE [EH_PH_POINTS] = '{
        2389000, 3371000, 5303000, 7459000, 10470000, 16290000, 22600000,
        31060000, 45950000, 59170000, 71530000, 77120000, 81700000, 83210000,
        83660000, 82850000, 81140000
    };
    localparam t_rate PH_RATE [EH_PH_POINTS] = '{
        4000000, 4500000, 4300000, 3690000, 3170000, 3047000, 3379000,
        4043000, 5471000, 7051000, 9167000, 10700000, 13010000, 14800000,
        16950000, 19750000, 22010000
    };

    // Width of a temperature compare: input width or scaled table point, whichever is wider.
    function automatic int cmp_w(input int frac);
        return (TEMP_W > TPOINT_W + frac) ? TEMP_W : TPOINT_W + frac;
    endfunction

    // Width of d * (k_hi - k_lo).
    function automatic int prod_w(input int frac);
        return cmp_w(frac) + 1 + RATE_W + 1;
    endfunction

    // Width of the rounded, pre-scaled dividend that enters the divider.
    function automatic int quo_w(input int frac);
        return prod_w(frac) + 1 - frac;
    endfunction

    function automatic t_idx last_idx(input logic [KIND_W-1:0] kind);
        t_idx r;
        case (kind)
            KIND_HH:          r = t_idx'(HH_POINTS - 1);
            KIND_EH, KIND_PH: r = t_idx'(EH_PH_POINTS - 1);
            default:          r = '0;
        endcase
        return r;
    endfunction

    function automatic t_tpoint point_temp(input logic [KIND_W-1:0] kind, input t_idx idx);
        t_tpoint t;
        t = '0;
        case (kind)
            KIND_HH: begin
                if (idx < t_idx'(HH_POINTS)) t = HH_TEMP[idx];
            end
            KIND_EH, KIND_PH: begin
                if (idx < t_idx'(EH_PH_POINTS)) t = XH_TEMP[idx];
            end
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic t_rate point_rate(input logic [KIND_W-1:0] kind, input t_idx idx);
        t_rate k;
        k = '0;
        case (kind)
            KIND_HH: begin
                if (idx < t_idx'(HH_POINTS)) k = HH_RATE[idx];
            end
            KIND_EH: begin
                if (idx < t_idx'(EH_PH_POINTS)) k = EH_RATE[idx];
            end
            KIND_PH: begin
                if (idx < t_idx'(EH_PH_POINTS)) k = PH_RATE[idx];
            end
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

// File: rtl/rtli_lookup.sv
// Segment search and table fetch: two pipeline stages.
// Depends on rtli_pkg (tables, widths, tag struct).
module rtli_lookup #(
    parameter int TEMP_FRAC_BITS = rtli_pkg::DEF_TEMP_FRAC_BITS
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_valid,
    input  logic [rtli_pkg::KIND_W-1:0]                     i_kind,
    input  logic [rtli_pkg::TEMP_W-1:0]                     i_temperature,
    output logic                                            o_valid,
    output rtli_pkg::t_tag                                  o_tag,
    output logic signed [rtli_pkg::cmp_w(TEMP_FRAC_BITS):0] o_d,
    output logic signed [rtli_pkg::RATE_W:0]                o_dk,
    output rtli_pkg::t_tpoint                               o_dt
);
    import rtli_pkg::*;

    localparam int CMP_W = cmp_w(TEMP_FRAC_BITS);
    localparam int D_W   = CMP_W + 1;
    localparam int DK_W  = RATE_W + 1;

    // Stage 1: segment index
    logic                r_s1_vld;
    logic [KIND_W-1:0]   r_s1_kind;
    logic [TEMP_W-1:0]   r_s1_temp;
    t_idx                r_s1_hi;
    logic                r_s1_ext;
    logic                r_s1_none;
    t_idx                n_s1_hi;
    logic                n_s1_ext;
    logic                n_s1_none;

    always_comb begin : c_search
        t_idx             last;
        t_idx             hi;
        logic [CMP_W-1:0] temp_c;
        logic [CMP_W-1:0] pt_j;
        logic [CMP_W-1:0] pt_first;
        logic [CMP_W-1:0] pt_last;
        last     = last_idx(i_kind);
        temp_c   = CMP_W'(i_temperature);
        hi       = t_idx'(1);
        for (int j = 1; j <= MAX_POINTS - 2; j++) begin
            pt_j = CMP_W'(point_temp(i_kind, t_idx'(j))) << TEMP_FRAC_BITS;
            if ((t_idx'(j) < last) && (temp_c > pt_j)) hi = t_idx'(j + 1);
        end
        pt_first  = CMP_W'(point_temp(i_kind, '0)) << TEMP_FRAC_BITS;
        pt_last   = CMP_W'(point_temp(i_kind, last)) << TEMP_FRAC_BITS;
        n_s1_hi   = hi;
        n_s1_none = !(i_kind inside {KIND_HH, KIND_EH, KIND_PH});
        n_s1_ext  = !n_s1_none && ((temp_c < pt_first) || (temp_c > pt_last));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_valid;
        end
        r_s1_kind <= i_kind;
        r_s1_temp <= i_temperature;
        r_s1_hi   <= n_s1_hi;
        r_s1_ext  <= n_s1_ext;
        r_s1_none <= n_s1_none;
    end

    // Stage 2: fetch segment end points, form differences
    logic                  r_s2_vld;
    t_tag                  r_s2_tag;
    logic signed [D_W-1:0] r_s2_d;
    logic signed [DK_W-1:0] r_s2_dk;
    t_tpoint               r_s2_dt;
    t_tag                  n_s2_tag;
    logic signed [D_W-1:0] n_s2_d;
    logic signed [DK_W-1:0] n_s2_dk;
    t_tpoint               n_s2_dt;

    always_comb begin : c_fetch
        t_idx             lo;
        t_tpoint          t_lo;
        t_tpoint          t_hi;
        t_rate            k_lo;
        t_rate            k_hi;
        logic [CMP_W-1:0] pt_lo;
        lo    = r_s1_hi - t_idx'(1);
        t_lo  = point_temp(r_s1_kind, lo);
        t_hi  = point_temp(r_s1_kind, r_s1_hi);
        k_lo  = point_rate(r_s1_kind, lo);
        k_hi  = point_rate(r_s1_kind, r_s1_hi);
        pt_lo = CMP_W'(t_lo) << TEMP_FRAC_BITS;
        n_s2_d        = $signed(D_W'(r_s1_temp) - D_W'(pt_lo));
        n_s2_dk       = $signed(DK_W'(k_hi) - DK_W'(k_lo));
        n_s2_dt       = t_hi - t_lo;
        n_s2_tag.none = r_s1_none;
        n_s2_tag.ext  = r_s1_ext;
        n_s2_tag.k_lo = k_lo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_tag <= n_s2_tag;
        r_s2_d   <= n_s2_d;
        r_s2_dk  <= n_s2_dk;
        r_s2_dt  <= n_s2_dt;
    end

    assign o_valid = r_s2_vld;
    assign o_tag   = r_s2_tag;
    assign o_d     = r_s2_d;
    assign o_dk    = r_s2_dk;
    assign o_dt    = r_s2_dt;

endmodule

// File: rtl/rtli_mul.sv
// Multiply, round and pre-scale: three pipeline stages feeding the divider.
// Depends on rtli_pkg (widths, tag struct).
module rtli_mul #(
    parameter int TEMP_FRAC_BITS = rtli_pkg::DEF_TEMP_FRAC_BITS
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_valid,
    input  rtli_pkg::t_tag                                   i_tag,
    input  logic signed [rtli_pkg::cmp_w(TEMP_FRAC_BITS):0]  i_d,
    input  logic signed [rtli_pkg::RATE_W:0]                 i_dk,
    input  rtli_pkg::t_tpoint                                i_dt,
    output logic                                             o_valid,
    output rtli_pkg::t_tag                                   o_tag,
    output logic [rtli_pkg::quo_w(TEMP_FRAC_BITS)-1:0]       o_u,
    output logic                                             o_neg,
    output rtli_pkg::t_tpoint                                o_dt
);
    import rtli_pkg::*;

    localparam int PROD_W = prod_w(TEMP_FRAC_BITS);
    localparam int X_W    = PROD_W + 2;
    localparam int Y_W    = quo_w(TEMP_FRAC_BITS);

    // Stage M1: product
    logic                     r_m1_vld;
    t_tag                     r_m1_tag;
    t_tpoint                  r_m1_dt;
    logic signed [PROD_W-1:0] r_m1_prod;
    logic signed [PROD_W-1:0] n_m1_prod;

    assign n_m1_prod = i_d * i_dk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
        end else begin
            r_m1_vld <= i_valid;
        end
        r_m1_tag  <= i_tag;
        r_m1_dt   <= i_dt;
        r_m1_prod <= n_m1_prod;
    end

    // Stage M2: add half divisor, drop the power-of-two part of the divisor (floor)
    logic                  r_m2_vld;
    t_tag                  r_m2_tag;
    t_tpoint               r_m2_dt;
    logic signed [Y_W-1:0] r_m2_y;
    logic signed [Y_W-1:0] n_m2_y;

    always_comb begin : c_round
        logic [X_W-1:0]        dt_sh;
        logic signed [X_W-1:0] x;
        dt_sh  = X_W'(r_m1_dt) << TEMP_FRAC_BITS;
        x      = $signed({r_m1_prod[PROD_W-1], r_m1_prod, 1'b0}) + $signed(dt_sh);
        n_m2_y = Y_W'(x >>> (TEMP_FRAC_BITS + 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_vld <= 1'b0;
        end else begin
            r_m2_vld <= r_m1_vld;
        end
        r_m2_tag <= r_m1_tag;
        r_m2_dt  <= r_m1_dt;
        r_m2_y   <= n_m2_y;
    end

    // Stage M3: sign and magnitude for the unsigned divider
    logic           r_m3_vld;
    t_tag           r_m3_tag;
    t_tpoint        r_m3_dt;
    logic           r_m3_neg;
    logic [Y_W-1:0] r_m3_u;
    logic           n_m3_neg;
    logic [Y_W-1:0] n_m3_u;

    assign n_m3_neg = r_m2_y[Y_W-1];
    assign n_m3_u   = n_m3_neg ? $unsigned(-r_m2_y) : $unsigned(r_m2_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3_vld <= 1'b0;
        end else begin
            r_m3_vld <= r_m2_vld;
        end
        r_m3_tag <= r_m2_tag;
        r_m3_dt  <= r_m2_dt;
        r_m3_neg <= n_m3_neg;
        r_m3_u   <= n_m3_u;
    end

    assign o_valid = r_m3_vld;
    assign o_tag   = r_m3_tag;
    assign o_u     = r_m3_u;
    assign o_neg   = r_m3_neg;
    assign o_dt    = r_m3_dt;

endmodule

// File: rtl/rtli_div.sv
// Pipelined restoring divider: DIV_STEP quotient bits per stage, narrow remainder.
// Depends on rtli_pkg (divisor type, step count, tag struct).
module rtli_div #(
    parameter int DIV_W = rtli_pkg::quo_w(rtli_pkg::DEF_TEMP_FRAC_BITS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  rtli_pkg::t_tag    i_tag,
    input  logic [DIV_W-1:0]  i_u,
    input  logic              i_neg,
    input  rtli_pkg::t_tpoint i_dt,
    output logic              o_valid,
    output rtli_pkg::t_tag    o_tag,
    output logic [DIV_W-1:0]  o_quo,
    output logic              o_rem_nz,
    output logic              o_neg
);
    import rtli_pkg::*;

    localparam int NSTG  = (DIV_W + DIV_STEP - 1) / DIV_STEP;
    localparam int PAD_W = NSTG * DIV_STEP;

    // Dividend bits shift out of the top of acc while quotient bits shift in at the bottom.
    logic             r_vld [NSTG];
    t_tag             r_tag [NSTG];
    logic             r_neg [NSTG];
    t_tpoint          r_div [NSTG];
    t_tpoint          r_rem [NSTG];
    logic [PAD_W-1:0] r_acc [NSTG];

    logic [PAD_W-1:0] w_acc [NSTG];
    t_tpoint          w_rem [NSTG];
    t_tpoint          w_div [NSTG];
    logic [PAD_W-1:0] n_acc [NSTG];
    t_tpoint          n_rem [NSTG];

    always_comb begin : c_link
        w_acc[0] = PAD_W'(i_u);
        w_rem[0] = '0;
        w_div[0] = i_dt;
        for (int g = 1; g < NSTG; g++) begin
            w_acc[g] = r_acc[g-1];
            w_rem[g] = r_rem[g-1];
            w_div[g] = r_div[g-1];
        end
    end

    always_comb begin : c_step
        logic [PAD_W-1:0]  acc;
        logic [TPOINT_W:0] t;
        t_tpoint           rem;
        for (int g = 0; g < NSTG; g++) begin
            acc = w_acc[g];
            rem = w_rem[g];
            for (int b = 0; b < DIV_STEP; b++) begin
                t   = {rem, acc[PAD_W-1]};
                acc = {acc[PAD_W-2:0], 1'b0};
                if (t >= {1'b0, w_div[g]}) begin
                    t      = t - {1'b0, w_div[g]};
                    acc[0] = 1'b1;
                end
                rem = t[TPOINT_W-1:0];
            end
            n_acc[g] = acc;
            n_rem[g] = rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < NSTG; g++) r_vld[g] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
            for (int g = 1; g < NSTG; g++) r_vld[g] <= r_vld[g-1];
        end
        r_tag[0] <= i_tag;
        r_neg[0] <= i_neg;
        for (int g = 1; g < NSTG; g++) begin
            r_tag[g] <= r_tag[g-1];
            r_neg[g] <= r_neg[g-1];
        end
        for (int g = 0; g < NSTG; g++) begin
            r_div[g] <= w_div[g];
            r_rem[g] <= n_rem[g];
            r_acc[g] <= n_acc[g];
        end
    end

    assign o_valid  = r_vld[NSTG-1];
    assign o_tag    = r_tag[NSTG-1];
    assign o_neg    = r_neg[NSTG-1];
    assign o_quo    = r_acc[NSTG-1][DIV_W-1:0];
    assign o_rem_nz = |r_rem[NSTG-1];

endmodule

// File: rtl/rate_table_linear_interp_unit.sv
// Collision rate table interpolator, top level: lookup, multiply, divide, saturate.
// Depends on rtli_pkg, rtli_lookup, rtli_mul, rtli_div and assert_macros.svh.
//
// Usage:
//   Input channel: drive i_kind (0 hydrogen-hydrogen, 1 electron-hydrogen,
//   2 proton-hydrogen) and i_temperature (kelvin, TEMP_FRAC_BITS fraction bits)
//   and raise start. A transaction is taken at each rising edge with start high
//   and busy low. busy is high only during reset and the cycle after it.
//   Output channel: o_strobe is high for exactly one cycle per transaction with
//   o_rate, o_saturated and o_extrapolated valid in that cycle. The receiver
//   cannot hold results off, so nothing ever stalls.
//   The divider works on quo_w = 55 - TEMP_FRAC_BITS bits for TEMP_FRAC_BITS
//   up to 9. Stages in order: segment search and table fetch, multiply and
//   rounding, the divider with DIV_STEP (four) quotient bits per stage, then
//   sign fix-up and saturation.
//   Throughput: one transaction per cycle whenever busy is low.
//   Reset (synchronous, active low) drops everything in flight; results come
//   out in the order transactions were taken. An unused kind gives all zeros.
`include "assert_macros.svh"

module rate_table_linear_interp_unit #(
    parameter int TEMP_FRAC_BITS = rtli_pkg::DEF_TEMP_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [rtli_pkg::KIND_W-1:0] i_kind,
    input  logic [rtli_pkg::TEMP_W-1:0] i_temperature,
    output logic                        o_strobe,
    output logic [rtli_pkg::RATE_W-1:0] o_rate,
    output logic                        o_saturated,
    output logic                        o_extrapolated
);
    import rtli_pkg::*;

    localparam int CMP_W = cmp_w(TEMP_FRAC_BITS);
    localparam int Y_W   = quo_w(TEMP_FRAC_BITS);
    localparam int QS_W  = Y_W + 1;
    localparam int R_W   = Y_W + 2;
    localparam int NSTG  = (Y_W + DIV_STEP - 1) / DIV_STEP;
    localparam int LAT   = 7 + NSTG;

    // Come out of reset through a register so busy covers the reset edge.
    logic r_ready;
    logic accept;
    logic unused_kind;
    logic zero_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
        end
    end

    assign busy   = ~r_ready;
    assign accept = start & ~busy;

    // Segment search and table fetch
    logic                   lk_valid;
    t_tag                   lk_tag;
    logic signed [CMP_W:0]  lk_d;
    logic signed [RATE_W:0] lk_dk;
    t_tpoint                lk_dt;

    rtli_lookup #(
        .TEMP_FRAC_BITS(TEMP_FRAC_BITS)
    ) u_lookup (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (accept),
        .i_kind        (i_kind),
        .i_temperature (i_temperature),
        .o_valid       (lk_valid),
        .o_tag         (lk_tag),
        .o_d           (lk_d),
        .o_dk          (lk_dk),
        .o_dt          (lk_dt)
    );

    // Multiply and round
    logic           mu_valid;
    t_tag           mu_tag;
    logic [Y_W-1:0] mu_u;
    logic           mu_neg;
    t_tpoint        mu_dt;

    rtli_mul #(
        .TEMP_FRAC_BITS(TEMP_FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (lk_valid),
        .i_tag   (lk_tag),
        .i_d     (lk_d),
        .i_dk    (lk_dk),
        .i_dt    (lk_dt),
        .o_valid (mu_valid),
        .o_tag   (mu_tag),
        .o_u     (mu_u),
        .o_neg   (mu_neg),
        .o_dt    (mu_dt)
    );

    // Divide by the segment width in whole kelvin
    logic           dv_valid;
    t_tag           dv_tag;
    logic [Y_W-1:0] dv_quo;
    logic           dv_rem_nz;
    logic           dv_neg;

    rtli_div #(
        .DIV_W(Y_W)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (mu_valid),
        .i_tag    (mu_tag),
        .i_u      (mu_u),
        .i_neg    (mu_neg),
        .i_dt     (mu_dt),
        .o_valid  (dv_valid),
        .o_tag    (dv_tag),
        .o_quo    (dv_quo),
        .o_rem_nz (dv_rem_nz),
        .o_neg    (dv_neg)
    );

    // Stage F1: restore the sign with floor semantics (a negative dividend
    // with a remainder rounds one further down).
    logic                   r_f1_vld;
    t_tag                   r_f1_tag;
    logic signed [QS_W-1:0] r_f1_q;
    logic signed [QS_W-1:0] n_f1_q;

    always_comb begin : c_sign
        logic [QS_W-1:0] qmag;
        qmag   = QS_W'(dv_quo) + QS_W'(dv_neg & dv_rem_nz);
        n_f1_q = dv_neg ? $signed(-qmag) : $signed(qmag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
        end else begin
            r_f1_vld <= dv_valid;
        end
        r_f1_tag <= dv_tag;
        r_f1_q   <= n_f1_q;
    end

    // Stage F2: add the segment base rate, clamp to the output range
    logic  r_strobe;
    t_rate r_rate;
    logic  r_sat;
    logic  r_ext;
    t_rate n_rate;
    logic  n_sat;
    logic  n_ext;

    always_comb begin : c_clamp
        logic signed [R_W-1:0] sum;
        sum = $signed(R_W'(r_f1_tag.k_lo)) + R_W'(r_f1_q);
        if (r_f1_tag.none) begin
            n_rate = '0;
            n_sat  = 1'b0;
        end else if (sum < 0) begin
            n_rate = '0;
            n_sat  = 1'b1;
        end else if (sum > $signed(R_W'(RATE_MAX))) begin
            n_rate = RATE_MAX;
            n_sat  = 1'b1;
        end else begin
            n_rate = sum[RATE_W-1:0];
            n_sat  = 1'b0;
        end
        n_ext = r_f1_tag.ext & ~r_f1_tag.none;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_f1_vld;
        end
        r_rate <= n_rate;
        r_sat  <= n_sat;
        r_ext  <= n_ext;
    end

    assign o_strobe       = r_strobe;
    assign o_rate         = r_rate;
    assign o_saturated    = r_sat;
    assign o_extrapolated = r_ext;

    // Terms for the checks below.
    assign unused_kind = !(i_kind inside {KIND_HH, KIND_EH, KIND_PH});
    assign zero_result = o_strobe && (o_rate == '0) && !o_saturated && !o_extrapolated;

    // Every accepted transaction comes out as a result strobe at the end of the pipeline.
    `ASSERT_DELAY(a_latency, start && !busy, LAT, o_strobe, "result strobe missing after latency")
    // An unused table select must give an all-zero result.
    `ASSERT_DELAY(a_unused_kind_zero, accept && unused_kind, LAT, zero_result, "unused kind nonzero")
    // A clamped result sits on one of the two range ends.
    `ASSERT_IMPL(a_sat_at_bound, o_strobe && o_saturated, o_rate == '0 || o_rate == RATE_MAX, "saturated rate not at a bound")

endmodule

// File: tb/rate_table_linear_interp_unit_tb.sv
// Self-checking testbench for rate_table_linear_interp_unit: a directed set of table ends,
// points and selectors, every table point streamed, then mixed random traffic checked on every strobe.
// Depends on rtli_pkg (kind codes and port widths) and the RTL of the block.
module rate_table_linear_interp_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 8;
    localparam int NPTS = 19;
    localparam int XPTS = 17;
    localparam int RATE_TOP = (1 << rtli_pkg::RATE_W) - 1;
    localparam int TEMP_TOP = (1 << rtli_pkg::TEMP_W) - 1;
    localparam logic [rtli_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Independent copy of the rate tables; the shorter ones are padded to 19 entries.
    localparam longint TBL_HH_T [NPTS] = '{
        1, 2, 4, 6, 8, 10, 15, 20, 25, 30, 40, 50, 60, 70, 80, 90, 100, 200, 300
    };
    localparam longint TBL_HH_K [NPTS] = '{
        1380, 1430, 2710, 6600, 14700, 28800, 91000, 178000, 273000, 367000,
        538000, 686000, 814000, 925000, 1020000, 1110000, 1190000, 1750000,
        2090000
    };
    localparam longint TBL_XH_T [NPTS] = '{
        1, 2, 5, 10, 20, 50, 100, 200, 500, 1000, 2000, 3000, 5000, 7000,
        10000, 15000, 20000, 0, 0
    };
    localparam longint TBL_EH_K [NPTS] = '{
        2389000, 3371000, 5303000, 7459000, 10470000, 16290000, 22600000,
        31060000, 45950000, 59170000, 71530000, 77120000, 81700000, 83210000,
        83660000, 82850000, 81140000, 0, 0
    };
    localparam longint TBL_PH_K [NPTS] = '{
        4000000, 4500000, 4300000, 3690000, 3170000, 3047000, 3379000,
        4043000, 5471000, 7051000, 9167000, 10700000, 13010000, 14800000,
        16950000, 19750000, 22010000, 0, 0
    };

    typedef struct {
        logic [rtli_pkg::KIND_W-1:0] kind;
        logic [rtli_pkg::TEMP_W-1:0] temp;
        logic [rtli_pkg::RATE_W-1:0] rate;
        logic                        sat;
        logic                        ext;
    } t_rate_expect;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [rtli_pkg::KIND_W-1:0] i_kind;
    logic [rtli_pkg::TEMP_W-1:0] i_temperature;
    logic                        o_strobe;
    logic [rtli_pkg::RATE_W-1:0] o_rate;
    logic                        o_saturated;
    logic                        o_extrapolated;

    t_rate_expect pending_rates[$];
    int           mismatch_count = 0;
    int           sent_count = 0;
    int           checked_count = 0;
    int           gap_max = 9;

    rate_table_linear_interp_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_temperature  (i_temperature),
        .o_strobe       (o_strobe),
        .o_rate         (o_rate),
        .o_saturated    (o_saturated),
        .o_extrapolated (o_extrapolated)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest correct run.
    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Number of points in the table that a kind selects.
    function automatic int table_points(input logic [rtli_pkg::KIND_W-1:0] kind);
        return (kind == rtli_pkg::KIND_HH) ? NPTS : XPTS;
    endfunction

    // Kelvin of point idx in the table that a kind selects.
    function automatic longint table_kelvin(input logic [rtli_pkg::KIND_W-1:0] kind,
                                            input int idx);
        return (kind == rtli_pkg::KIND_HH) ? TBL_HH_T[idx] : TBL_XH_T[idx];
    endfunction

    // Work out the interpolated, rounded and clamped rate for one transaction.
    function automatic t_rate_expect interp_rate(input logic [rtli_pkg::KIND_W-1:0] kind,
                                                 input logic [rtli_pkg::TEMP_W-1:0] temp);
        t_rate_expect res;
        longint       tk [NPTS];
        longint       kv [NPTS];
        longint       t;
        longint       d;
        longint       num;
        longint       den;
        longint       a;
        longint       b;
        longint       q;
        longint       r;
        int           n;
        int           hi;
        int           lo;
        res.kind = kind;
        res.temp = temp;
        res.rate = '0;
        res.sat  = 1'b0;
        res.ext  = 1'b0;
        case (kind)
            rtli_pkg::KIND_HH: begin
                tk = TBL_HH_T;
                kv = TBL_HH_K;
            end
            rtli_pkg::KIND_EH: begin
                tk = TBL_XH_T;
                kv = TBL_EH_K;
            end
            rtli_pkg::KIND_PH: begin
                tk = TBL_XH_T;
                kv = TBL_PH_K;
            end
            default: begin
                // Unused selector: all-zero result.
                return res;
            end
        endcase
        n = table_points(kind);
        t = longint'(temp);
        // Pick the segment: inner points strictly below the temperature move it up.
        hi = 1;
        for (int j = 1; j <= n - 2; j++) begin
            if (t > (tk[j] << FRAC)) hi = j + 1;
        end
        lo = hi - 1;
        res.ext = (t < (tk[0] << FRAC)) || (t > (tk[n-1] << FRAC));
        d   = t - (tk[lo] << FRAC);
        num = d * (kv[hi] - kv[lo]);
        den = (tk[hi] - tk[lo]) << FRAC;
        // Round to nearest, half up: floor((2*num + den) / (2*den)).
        a = 2 * num + den;
        b = 2 * den;
        q = a / b;
        if (a < 0 && q * b != a) q = q - 1;
        r = kv[lo] + q;
        if (r < 0) begin
            r = 0;
            res.sat = 1'b1;
        end else if (r > RATE_TOP) begin
            r = RATE_TOP;
            res.sat = 1'b1;
        end
        res.rate = r[rtli_pkg::RATE_W-1:0];
        return res;
    endfunction

    // Send one transaction after a random gap. Left just after a rising edge.
    task automatic send_reading(input logic [rtli_pkg::KIND_W-1:0] kind,
                                input logic [rtli_pkg::TEMP_W-1:0] temp);
        int gap;
        gap = $urandom_range(0, gap_max);
        // Drop start for the gap; with no gap it stays high and only the fields change.
        repeat (gap) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start         = 1'b1;
        i_kind        = kind;
        i_temperature = temp;
        // Hold the transaction until an edge sees busy low.
        do @(posedge i_clk); while (busy);
        pending_rates.push_back(interp_rate(kind, temp));
        sent_count++;
    endtask

    // Pause the sender until every expected result has come out.
    task automatic drain_results();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_rates.size() != 0) @(posedge i_clk);
    endtask

    // Check each strobed result against the oldest expectation.
    always @(posedge i_clk) begin
        t_rate_expect exp_r;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_rates.size() == 0) begin
                $error("result with no transaction outstanding: rate %0d", o_rate);
                mismatch_count++;
            end else begin
                exp_r = pending_rates.pop_front();
                checked_count++;
                if (o_rate !== exp_r.rate) begin
                    $error("rate mismatch (kind %0d temp 0x%06h): expected %0d, actual %0d",
                           exp_r.kind, exp_r.temp, exp_r.rate, o_rate);
                    mismatch_count++;
                end
                if (o_saturated !== exp_r.sat) begin
                    $error("saturated mismatch (kind %0d temp 0x%06h): expected %0b, actual %0b",
                           exp_r.kind, exp_r.temp, exp_r.sat, o_saturated);
                    mismatch_count++;
                end
                if (o_extrapolated !== exp_r.ext) begin
                    $error("extrapolated mismatch (kind %0d temp 0x%06h): expected %0b, actual %0b",
                           exp_r.kind, exp_r.temp, exp_r.ext, o_extrapolated);
                    mismatch_count++;
                end
            end
        end
    end

    // Table ends, exact points, just past a point, far outside, and the unused selector.
    task automatic test_directed_corners();
        logic [rtli_pkg::KIND_W-1:0] kind;
        int                          last;
        for (int k = 0; k < 3; k++) begin
            kind = k[rtli_pkg::KIND_W-1:0];
            last = table_points(kind) - 1;
            send_reading(kind, '0);                               // below first point
            send_reading(kind, 24'd128);                          // between 0 and first
            send_reading(kind, 24'(table_kelvin(kind, 0) << FRAC)); // first point exactly
            send_reading(kind, 24'(table_kelvin(kind, 7) << FRAC)); // inner point exactly
            send_reading(kind, 24'((table_kelvin(kind, 7) << FRAC) + 1)); // just past it
            send_reading(kind, 24'(table_kelvin(kind, last) << FRAC)); // last point exactly
            send_reading(kind, 24'(TEMP_TOP));                    // far above last point
        end
        send_reading(KIND_UNUSED, '0);
        send_reading(KIND_UNUSED, 24'(TEMP_TOP));
    endtask

    // Every point of every table, back to back, with no idling.
    task automatic test_points_streaming();
        logic [rtli_pkg::KIND_W-1:0] kind;
        gap_max = 0;
        for (int k = 0; k < 3; k++) begin
            kind = k[rtli_pkg::KIND_W-1:0];
            for (int p = 0; p < table_points(kind); p++)
                send_reading(kind, 24'(table_kelvin(kind, p) << FRAC));
        end
        gap_max = 9;
    endtask

    // Mixed random traffic: mostly near table points and inside the table range.
    task automatic test_random_traffic(input int count);
        logic [rtli_pkg::KIND_W-1:0] kind;
        int                          sel;
        int                          pick;
        longint                      val;
        for (int i = 0; i < count; i++) begin
            // Switch idling on and off in stretches; drain now and then.
            if (i % 250 == 0) gap_max = (gap_max == 0) ? 9 : 0;
            if (i % 400 == 399) drain_results();
            sel  = $urandom_range(0, 9);
            kind = (sel < 3) ? rtli_pkg::KIND_HH :
                   (sel < 6) ? rtli_pkg::KIND_EH :
                   (sel < 9) ? rtli_pkg::KIND_PH : KIND_UNUSED;
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                // Near a table point, either side.
                val = (table_kelvin(kind, $urandom_range(0, table_points(kind) - 1)) << FRAC)
                      + longint'($urandom_range(0, 1024)) - 512;
            end else if (pick < 7) begin
                // Anywhere in the table's span, plus a little beyond.
                val = $urandom_range(0, int'(table_kelvin(kind, table_points(kind) - 1)
                                             << FRAC) + 256);
            end else begin
                val = $urandom_range(0, TEMP_TOP);
            end
            if (val < 0) val = 0;
            if (val > TEMP_TOP) val = TEMP_TOP;
            send_reading(kind, val[rtli_pkg::TEMP_W-1:0]);
        end
        gap_max = 9;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_kind        = '0;
        i_temperature = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_corners();
        drain_results();
        test_points_streaming();
        test_random_traffic(1500);

        // Stop sending, let the pipeline empty, then give it its latency again.
        drain_results();
        repeat (40) @(posedge i_clk);
        if (pending_rates.size() != 0) begin
            $error("%0d expected results never arrived", pending_rates.size());
            mismatch_count++;
        end
        $display("Sent %0d transactions over all three tables and the unused selector,",
                 sent_count);
        $display("with exact points, extrapolation both ways and random gaps; %0d checked.",
                 checked_count);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
